// ----- sv/spd2_pkg.sv -----
// shared types and constants for the segment pair distance block
package spd2_pkg;

	// coordinate width of every endpoint field
	localparam int COORD_BITS = 16;
	// width of the distance result
	localparam int DIST_W = 25;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	// one segment pair: segment 1 runs start to end, segment 2 likewise
	typedef struct packed {
		coord_t seg1_start_x;
		coord_t seg1_start_y;
		coord_t seg1_end_x;
		coord_t seg1_end_y;
		coord_t seg2_start_x;
		coord_t seg2_start_y;
		coord_t seg2_end_x;
		coord_t seg2_end_y;
	} pair_t;

	// one result: fixed point distance and crossing flag
	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic              crossing;
	} dist_t;

endpackage

// ----- sv/segment_pair_distance_2d.sv -----
// segment pair distance pipeline: crossing test, four point-segment distances, root
//
// Usage: a segment pair enters on the pair channel (pair_valid, pair_stall, pair) and
// its result leaves on the dist channel (dist_valid, dist_stall, result). Every pair
// gives exactly one result, in order.
// Throughput: one pair per cycle while no shown result is held by dist_stall.
// The depth is set by the restoring divider (one quotient bit per stage,
// 2*COORD_BITS+1+2*FRAC_BITS stages) and the square root (one root bit per stage,
// COORD_BITS+FRAC_BITS+1 stages) that follow the cross and dot product stages.
// The distance is the exact Euclidean distance with FRAC_BITS fraction bits,
// rounded down, saturated to the result width; a crossing gives distance zero.
// Reset clears every stage valid bit, so no result appears until pairs are sent.
// When the receiver holds dist_stall while a result is shown, the whole pipeline
// holds and pair_stall is raised; nothing is lost or repeated, and the pipeline
// moves again as soon as dist_stall drops.
module segment_pair_distance_2d
	import spd2_pkg::*;
#(
	parameter int FRAC_BITS = 8
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  pair_valid,
	output logic  pair_stall,
	input  pair_t pair,
	output logic  dist_valid,
	input  logic  dist_stall,
	output dist_t result
);

	localparam int C     = COORD_BITS;
	localparam int EW    = C + 1;              // coordinate difference
	localparam int PW    = 2 * EW;             // product of two differences
	localparam int SW    = PW + 1;             // sum of two products
	localparam int DW    = 2 * C + 1;          // squared length, cross magnitude
	localparam int NW    = 2 * DW;             // squared cross magnitude
	localparam int QW    = DW + 2 * FRAC_BITS; // quotient of squared distance
	localparam int XW    = NW + 2 * FRAC_BITS; // dividend
	localparam int RT    = (QW + 1) / 2;       // root bits
	localparam int HL    = (DW + 1) / 2;       // low half for the split square
	localparam int HH    = DW - HL;
	localparam int LANES = 4;

	logic en;

	// the pipeline moves unless a shown result is held
	assign en         = !(dist_valid && dist_stall);
	assign pair_stall = !en;

	function automatic logic signed [PW-1:0] smul(logic signed [EW-1:0] x,
		logic signed [EW-1:0] y);
		return PW'(x) * PW'(y);
	endfunction

	function automatic logic [DW-1:0] sabs(logic signed [SW-1:0] x);
		logic signed [SW-1:0] m;
		m = (x < 0) ? -x : x;
		return DW'(m);
	endfunction

	// one restoring division step: returns {remainder, shifted low/quotient}
	function automatic logic [DW+QW-1:0] div_step(logic [DW-1:0] rem,
		logic [QW-1:0] low, logic [DW-1:0] dv);
		logic [DW:0] t;
		logic [DW:0] d;
		logic        ge;
		t  = {rem, low[QW-1]};
		d  = {1'b0, dv};
		ge = (t >= d);
		if (ge) begin
			t = t - d;
		end
		return {t[DW-1:0], low[QW-2:0], ge};
	endfunction

	// one digit of the square root: returns {remainder, root, radicand}
	function automatic logic [RT+2+RT+2*RT-1:0] sq_step(logic [RT+1:0] rem,
		logic [RT-1:0] root, logic [2*RT-1:0] x);
		logic [RT+1:0] r2;
		logic [RT+1:0] trial;
		logic          ge;
		r2    = {rem[RT-1:0], x[2*RT-1 -: 2]};
		trial = {root, 2'b01};
		ge    = (r2 >= trial);
		if (ge) begin
			r2 = r2 - trial;
		end
		return {r2, root[RT-2:0], ge, x[2*RT-3:0], 2'b00};
	endfunction

	// ---------------- stage 1: coordinate differences ----------------
	logic v_s1;
	logic signed [EW-1:0] e1x_s1, e1y_s1, e2x_s1, e2y_s1;
	logic signed [EW-1:0] acx_s1, acy_s1, adx_s1, ady_s1;
	logic signed [EW-1:0] bcx_s1, bcy_s1, bdx_s1, bdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= pair_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e1x_s1 <= EW'(pair.seg1_end_x) - EW'(pair.seg1_start_x);
			e1y_s1 <= EW'(pair.seg1_end_y) - EW'(pair.seg1_start_y);
			e2x_s1 <= EW'(pair.seg2_end_x) - EW'(pair.seg2_start_x);
			e2y_s1 <= EW'(pair.seg2_end_y) - EW'(pair.seg2_start_y);
			acx_s1 <= EW'(pair.seg1_start_x) - EW'(pair.seg2_start_x);
			acy_s1 <= EW'(pair.seg1_start_y) - EW'(pair.seg2_start_y);
			adx_s1 <= EW'(pair.seg1_start_x) - EW'(pair.seg2_end_x);
			ady_s1 <= EW'(pair.seg1_start_y) - EW'(pair.seg2_end_y);
			bcx_s1 <= EW'(pair.seg1_end_x) - EW'(pair.seg2_start_x);
			bcy_s1 <= EW'(pair.seg1_end_y) - EW'(pair.seg2_start_y);
			bdx_s1 <= EW'(pair.seg1_end_x) - EW'(pair.seg2_end_x);
			bdy_s1 <= EW'(pair.seg1_end_y) - EW'(pair.seg2_end_y);
		end
	end

	// ---------------- stage 2: products ----------------
	logic v_s2;
	logic signed [PW-1:0] p_e1x_e2y_s2, p_e1y_e2x_s2;
	logic signed [PW-1:0] p_acx_e2y_s2, p_acy_e2x_s2, p_acx_e1y_s2, p_acy_e1x_s2;
	logic signed [PW-1:0] p_bcx_e2y_s2, p_bcy_e2x_s2, p_adx_e1y_s2, p_ady_e1x_s2;
	logic signed [PW-1:0] p_acx_e2x_s2, p_acy_e2y_s2, p_bcx_e2x_s2, p_bcy_e2y_s2;
	logic signed [PW-1:0] p_acx_e1x_s2, p_acy_e1y_s2, p_adx_e1x_s2, p_ady_e1y_s2;
	logic signed [PW-1:0] p_e1x_e1x_s2, p_e1y_e1y_s2, p_e2x_e2x_s2, p_e2y_e2y_s2;
	logic signed [PW-1:0] p_acx2_s2, p_acy2_s2, p_adx2_s2, p_ady2_s2;
	logic signed [PW-1:0] p_bcx2_s2, p_bcy2_s2, p_bdx2_s2, p_bdy2_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_e1x_e2y_s2 <= smul(e1x_s1, e2y_s1);
			p_e1y_e2x_s2 <= smul(e1y_s1, e2x_s1);
			p_acx_e2y_s2 <= smul(acx_s1, e2y_s1);
			p_acy_e2x_s2 <= smul(acy_s1, e2x_s1);
			p_acx_e1y_s2 <= smul(acx_s1, e1y_s1);
			p_acy_e1x_s2 <= smul(acy_s1, e1x_s1);
			p_bcx_e2y_s2 <= smul(bcx_s1, e2y_s1);
			p_bcy_e2x_s2 <= smul(bcy_s1, e2x_s1);
			p_adx_e1y_s2 <= smul(adx_s1, e1y_s1);
			p_ady_e1x_s2 <= smul(ady_s1, e1x_s1);
			p_acx_e2x_s2 <= smul(acx_s1, e2x_s1);
			p_acy_e2y_s2 <= smul(acy_s1, e2y_s1);
			p_bcx_e2x_s2 <= smul(bcx_s1, e2x_s1);
			p_bcy_e2y_s2 <= smul(bcy_s1, e2y_s1);
			p_acx_e1x_s2 <= smul(acx_s1, e1x_s1);
			p_acy_e1y_s2 <= smul(acy_s1, e1y_s1);
			p_adx_e1x_s2 <= smul(adx_s1, e1x_s1);
			p_ady_e1y_s2 <= smul(ady_s1, e1y_s1);
			p_e1x_e1x_s2 <= smul(e1x_s1, e1x_s1);
			p_e1y_e1y_s2 <= smul(e1y_s1, e1y_s1);
			p_e2x_e2x_s2 <= smul(e2x_s1, e2x_s1);
			p_e2y_e2y_s2 <= smul(e2y_s1, e2y_s1);
			p_acx2_s2    <= smul(acx_s1, acx_s1);
			p_acy2_s2    <= smul(acy_s1, acy_s1);
			p_adx2_s2    <= smul(adx_s1, adx_s1);
			p_ady2_s2    <= smul(ady_s1, ady_s1);
			p_bcx2_s2    <= smul(bcx_s1, bcx_s1);
			p_bcy2_s2    <= smul(bcy_s1, bcy_s1);
			p_bdx2_s2    <= smul(bdx_s1, bdx_s1);
			p_bdy2_s2    <= smul(bdy_s1, bdy_s1);
		end
	end

	// ---------------- stage 3: cross, dot and squared sums ----------------
	logic v_s3;
	logic signed [SW-1:0] den_s3, tn_s3, un_s3, cr1_s3, cr3_s3;
	logic signed [SW-1:0] dot_s3 [LANES];
	logic [DW-1:0] len1_s3, len2_s3, ep_ac_s3, ep_ad_s3, ep_bc_s3, ep_bd_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s3    <= SW'(p_e1x_e2y_s2) - SW'(p_e1y_e2x_s2);
			tn_s3     <= SW'(p_acy_e2x_s2) - SW'(p_acx_e2y_s2);
			un_s3     <= SW'(p_acy_e1x_s2) - SW'(p_acx_e1y_s2);
			cr1_s3    <= SW'(p_bcx_e2y_s2) - SW'(p_bcy_e2x_s2);
			cr3_s3    <= SW'(p_adx_e1y_s2) - SW'(p_ady_e1x_s2);
			dot_s3[0] <= SW'(p_acx_e2x_s2) + SW'(p_acy_e2y_s2);
			dot_s3[1] <= SW'(p_bcx_e2x_s2) + SW'(p_bcy_e2y_s2);
			dot_s3[2] <= -(SW'(p_acx_e1x_s2) + SW'(p_acy_e1y_s2));
			dot_s3[3] <= -(SW'(p_adx_e1x_s2) + SW'(p_ady_e1y_s2));
			len1_s3   <= DW'(SW'(p_e1x_e1x_s2) + SW'(p_e1y_e1y_s2));
			len2_s3   <= DW'(SW'(p_e2x_e2x_s2) + SW'(p_e2y_e2y_s2));
			ep_ac_s3  <= DW'(SW'(p_acx2_s2) + SW'(p_acy2_s2));
			ep_ad_s3  <= DW'(SW'(p_adx2_s2) + SW'(p_ady2_s2));
			ep_bc_s3  <= DW'(SW'(p_bcx2_s2) + SW'(p_bcy2_s2));
			ep_bd_s3  <= DW'(SW'(p_bdx2_s2) + SW'(p_bdy2_s2));
		end
	end

	// ---------------- stage 4: crossing test and lane case select ----------------
	// lanes: seg1 start and seg1 end against seg2, seg2 start and seg2 end against seg1
	logic [DW-1:0]        l_len [LANES];
	logic [DW-1:0]        l_cr  [LANES];
	logic [DW-1:0]        l_st  [LANES];
	logic [DW-1:0]        l_end [LANES];
	logic                 cross_c;

	always_comb begin
		l_len[0] = len2_s3;  l_cr[0] = sabs(tn_s3);
		l_st[0]  = ep_ac_s3; l_end[0] = ep_ad_s3;
		l_len[1] = len2_s3;  l_cr[1] = sabs(cr1_s3);
		l_st[1]  = ep_bc_s3; l_end[1] = ep_bd_s3;
		l_len[2] = len1_s3;  l_cr[2] = sabs(un_s3);
		l_st[2]  = ep_ac_s3; l_end[2] = ep_bc_s3;
		l_len[3] = len1_s3;  l_cr[3] = sabs(cr3_s3);
		l_st[3]  = ep_ad_s3; l_end[3] = ep_bd_s3;
		cross_c = ((den_s3 > 0) && (tn_s3 >= 0) && (tn_s3 <= den_s3)
				&& (un_s3 >= 0) && (un_s3 <= den_s3))
			|| ((den_s3 < 0) && (tn_s3 <= 0) && (tn_s3 >= den_s3)
				&& (un_s3 <= 0) && (un_s3 >= den_s3));
	end

	logic v_s4, cross_s4;
	logic          seg_s4 [LANES];
	logic [DW-1:0] mag_s4 [LANES];
	logic [DW-1:0] dv_s4  [LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cross_s4 <= cross_c;
		end
	end

	genvar gl, gk;
	generate
		for (gl = 0; gl < LANES; gl++) begin : g_sel
			// clamp: before the start, past the end, or the perpendicular foot
			always_ff @(posedge clk) begin
				if (en) begin
					if (l_len[gl] == '0 || dot_s3[gl] <= 0) begin
						seg_s4[gl] <= 1'b0;
						mag_s4[gl] <= l_st[gl];
						dv_s4[gl]  <= DW'(1);
					end else if (dot_s3[gl] >= $signed(SW'(l_len[gl]))) begin
						seg_s4[gl] <= 1'b0;
						mag_s4[gl] <= l_end[gl];
						dv_s4[gl]  <= DW'(1);
					end else begin
						seg_s4[gl] <= 1'b1;
						mag_s4[gl] <= l_cr[gl];
						dv_s4[gl]  <= l_len[gl];
					end
				end
			end
		end
	endgenerate

	// ---------------- stage 5: split square of the cross magnitude ----------------
	logic v_s5, cross_s5;
	logic               seg_s5 [LANES];
	logic [DW-1:0]      mag_s5 [LANES];
	logic [DW-1:0]      dv_s5  [LANES];
	logic [2*HH-1:0]    hh_s5  [LANES];
	logic [HH+HL-1:0]   hl_s5  [LANES];
	logic [2*HL-1:0]    ll_s5  [LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cross_s5 <= cross_s4;
		end
	end

	generate
		for (gl = 0; gl < LANES; gl++) begin : g_sq
			always_ff @(posedge clk) begin
				if (en) begin
					seg_s5[gl] <= seg_s4[gl];
					mag_s5[gl] <= mag_s4[gl];
					dv_s5[gl]  <= dv_s4[gl];
					hh_s5[gl]  <= (2*HH)'(mag_s4[gl][DW-1:HL])
						* (2*HH)'(mag_s4[gl][DW-1:HL]);
					hl_s5[gl]  <= (HH+HL)'(mag_s4[gl][DW-1:HL])
						* (HH+HL)'(mag_s4[gl][HL-1:0]);
					ll_s5[gl]  <= (2*HL)'(mag_s4[gl][HL-1:0])
						* (2*HL)'(mag_s4[gl][HL-1:0]);
				end
			end
		end
	endgenerate

	// ---------------- divider: squared distance with 2*FRAC_BITS fraction bits ------
	logic          div_v_s   [QW+1];
	logic          div_c_s   [QW+1];
	logic [DW-1:0] div_rem_s [QW+1][LANES];
	logic [QW-1:0] div_low_s [QW+1][LANES];
	logic [DW-1:0] div_dv_s  [QW+1][LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_v_s[0] <= 1'b0;
		end else if (en) begin
			div_v_s[0] <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_c_s[0] <= cross_s5;
		end
	end

	generate
		for (gl = 0; gl < LANES; gl++) begin : g_dvd
			logic [NW-1:0] num;
			logic [XW-1:0] dvd;

			// numerator: cross squared on the segment case, endpoint distance otherwise
			always_comb begin
				num = seg_s5[gl]
					? ((NW'(hh_s5[gl]) << (2*HL)) + (NW'(hl_s5[gl]) << (HL+1))
						+ NW'(ll_s5[gl]))
					: NW'(mag_s5[gl]);
				dvd = XW'(num) << (2*FRAC_BITS);
			end

			always_ff @(posedge clk) begin
				if (en) begin
					div_rem_s[0][gl] <= dvd[XW-1:QW];
					div_low_s[0][gl] <= dvd[QW-1:0];
					div_dv_s[0][gl]  <= dv_s5[gl];
				end
			end
		end

		for (gk = 0; gk < QW; gk++) begin : g_div
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					div_v_s[gk+1] <= 1'b0;
				end else if (en) begin
					div_v_s[gk+1] <= div_v_s[gk];
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					div_c_s[gk+1] <= div_c_s[gk];
				end
			end

			for (gl = 0; gl < LANES; gl++) begin : g_lane
				always_ff @(posedge clk) begin
					if (en) begin
						{div_rem_s[gk+1][gl], div_low_s[gk+1][gl]} <=
							div_step(div_rem_s[gk][gl], div_low_s[gk][gl],
								div_dv_s[gk][gl]);
						div_dv_s[gk+1][gl] <= div_dv_s[gk][gl];
					end
				end
			end
		end
	endgenerate

	// ---------------- least of the four lanes ----------------
	logic          v_m1, cross_m1;
	logic [QW-1:0] min01_m1, min23_m1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_m1 <= 1'b0;
		end else if (en) begin
			v_m1 <= div_v_s[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cross_m1 <= div_c_s[QW];
			min01_m1 <= (div_low_s[QW][1] < div_low_s[QW][0])
				? div_low_s[QW][1] : div_low_s[QW][0];
			min23_m1 <= (div_low_s[QW][3] < div_low_s[QW][2])
				? div_low_s[QW][3] : div_low_s[QW][2];
		end
	end

	// ---------------- square root, one root bit per stage ----------------
	logic            sq_v_s    [RT+1];
	logic            sq_c_s    [RT+1];
	logic [RT+1:0]   sq_rem_s  [RT+1];
	logic [RT-1:0]   sq_root_s [RT+1];
	logic [2*RT-1:0] sq_x_s    [RT+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_v_s[0] <= 1'b0;
		end else if (en) begin
			sq_v_s[0] <= v_m1;
		end
	end

	// a crossing forces the radicand to zero
	always_ff @(posedge clk) begin
		if (en) begin
			sq_c_s[0]    <= cross_m1;
			sq_rem_s[0]  <= '0;
			sq_root_s[0] <= '0;
			if (cross_m1) begin
				sq_x_s[0] <= '0;
			end else begin
				sq_x_s[0] <= (min23_m1 < min01_m1) ? (2*RT)'(min23_m1)
					: (2*RT)'(min01_m1);
			end
		end
	end

	generate
		for (gk = 0; gk < RT; gk++) begin : g_root
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					sq_v_s[gk+1] <= 1'b0;
				end else if (en) begin
					sq_v_s[gk+1] <= sq_v_s[gk];
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					sq_c_s[gk+1] <= sq_c_s[gk];
					{sq_rem_s[gk+1], sq_root_s[gk+1], sq_x_s[gk+1]} <=
						sq_step(sq_rem_s[gk], sq_root_s[gk], sq_x_s[gk]);
				end
			end
		end
	endgenerate

	// ---------------- output register with saturation ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_valid <= 1'b0;
		end else if (en) begin
			dist_valid <= sq_v_s[RT];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result.crossing <= sq_c_s[RT];
			if ((sq_root_s[RT] >> DIST_W) != '0) begin
				result.distance <= '1;
			end else begin
				result.distance <= DIST_W'(sq_root_s[RT]);
			end
		end
	end

endmodule

// ----- sv/spd2_checker.sv -----
// port checker for the segment pair distance block, bound to the top level
module spd2_checker
	import spd2_pkg::*;
(
	input logic  clk,
	input logic  arst_n,
	input logic  pair_valid,
	input logic  pair_stall,
	input logic  dist_valid,
	input logic  dist_stall,
	input dist_t result
);

	// intake holds exactly while a shown result is held
	a_stall_follows: assert property (@(posedge clk) disable iff (!arst_n)
		pair_stall == (dist_valid && dist_stall))
		else $error("pair_stall does not follow the held result");

	// a held result stays shown and unchanged
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dist_valid && dist_stall |=> dist_valid && $stable(result))
		else $error("held result changed");

	// a crossing always reports zero distance
	a_cross_zero: assert property (@(posedge clk) disable iff (!arst_n)
		dist_valid && result.crossing |-> result.distance == '0)
		else $error("crossing with nonzero distance");

	// no pair can be refused while the result side is free
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		pair_valid && !dist_valid |-> !pair_stall)
		else $error("pair refused with no result waiting");

endmodule

bind segment_pair_distance_2d spd2_checker u_spd2_checker (.*);

// ----- sim/segment_pair_distance_2d_chk.sv -----
// transfer monitor, distance predictor and result checker for the segment pair block
`timescale 1ns / 100ps

module segment_pair_distance_2d_chk
	import spd2_pkg::*;
#(
	parameter int FRAC_BITS = 8
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  pair_valid,
	input  logic  pair_stall,
	input  pair_t pair,
	input  logic  dist_valid,
	input  logic  dist_stall,
	input  dist_t result,
	output int    fails,
	output int    pending
);

	localparam logic [DIST_W-1:0] DIST_SAT = '1;

	dist_t expected_dists[$];

	// floor(sqrt(num / den) * 2^FRAC_BITS), exact, by bitwise search
	function automatic logic [63:0] fixed_sqrt_ratio(logic [127:0] num, logic [63:0] den);
		logic [191:0] scaled;
		logic [191:0] sq;
		logic [63:0]  root;
		logic [63:0]  cand;
		scaled = {64'd0, num} << (2 * FRAC_BITS);
		root = '0;
		for (int b = 47; b >= 0; b--) begin
			cand = root | (64'd1 << b);
			sq = {128'd0, cand} * {128'd0, cand};
			sq = sq * {128'd0, den};
			if (sq <= scaled)
				root = cand;
		end
		return root;
	endfunction

	function automatic logic [63:0] endpoint_gap(longint px, longint py, longint qx, longint qy);
		longint dx, dy;
		dx = px - qx;
		dy = py - qy;
		return fixed_sqrt_ratio(128'(dx * dx + dy * dy), 64'd1);
	endfunction

	// distance from point p to segment s-e with clamped projection
	function automatic logic [63:0] point_to_segment(longint sx, longint sy, longint ex,
			longint ey, longint px, longint py);
		longint dx, dy, wx, wy, len2, dot, crs;
		logic [127:0] crs_mag;
		dx = ex - sx;
		dy = ey - sy;
		wx = px - sx;
		wy = py - sy;
		len2 = dx * dx + dy * dy;
		dot = wx * dx + wy * dy;
		if (len2 == 0 || dot <= 0)
			return endpoint_gap(px, py, sx, sy);
		if (dot >= len2)
			return endpoint_gap(px, py, ex, ey);
		crs = wx * dy - wy * dx;
		crs_mag = 128'(crs < 0 ? -crs : crs);
		return fixed_sqrt_ratio(crs_mag * crs_mag, 64'(len2));
	endfunction

	function automatic dist_t predict_pair(pair_t p);
		longint ax, ay, bx, by, cx, cy, dx, dy;
		longint e1x, e1y, e2x, e2y, wx, wy, den, tn, un;
		logic [63:0] best, v;
		logic hit;
		dist_t r;
		ax = p.seg1_start_x; ay = p.seg1_start_y; bx = p.seg1_end_x; by = p.seg1_end_y;
		cx = p.seg2_start_x; cy = p.seg2_start_y; dx = p.seg2_end_x; dy = p.seg2_end_y;
		e1x = bx - ax; e1y = by - ay; e2x = dx - cx; e2y = dy - cy;
		wx = cx - ax; wy = cy - ay;
		den = e1x * e2y - e1y * e2x;
		hit = 1'b0;
		// parallel and collinear pairs never count as crossing
		if (den != 0) begin
			tn = wx * e2y - wy * e2x;
			un = wx * e1y - wy * e1x;
			if (den < 0) begin
				den = -den; tn = -tn; un = -un;
			end
			hit = tn >= 0 && tn <= den && un >= 0 && un <= den;
		end
		if (hit) begin
			best = '0;
		end else begin
			best = point_to_segment(cx, cy, dx, dy, ax, ay);
			v = point_to_segment(cx, cy, dx, dy, bx, by); if (v < best) best = v;
			v = point_to_segment(ax, ay, bx, by, cx, cy); if (v < best) best = v;
			v = point_to_segment(ax, ay, bx, by, dx, dy); if (v < best) best = v;
		end
		r.distance = (best > 64'(DIST_SAT)) ? DIST_SAT : best[DIST_W-1:0];
		r.crossing = hit;
		return r;
	endfunction

	assign pending = expected_dists.size();

	// predict on each input transfer, compare on each output transfer
	always @(posedge clk or negedge arst_n) begin
		dist_t exp_d;
		if (!arst_n) begin
			fails <= 0;
		end else begin
			if (dist_valid && !dist_stall) begin
				if (expected_dists.size() == 0) begin
					$display("%0t: unexpected result distance=%0d crossing=%0b", $time,
						result.distance, result.crossing);
					fails <= fails + 1;
				end else begin
					exp_d = expected_dists.pop_front();
					if (exp_d.distance !== result.distance
							|| exp_d.crossing !== result.crossing) begin
						$display("%0t: expected distance=%0d crossing=%0b, got distance=%0d crossing=%0b",
							$time, exp_d.distance, exp_d.crossing, result.distance,
							result.crossing);
						fails <= fails + 1;
					end
				end
			end
			if (pair_valid && !pair_stall)
				expected_dists.insert(expected_dists.size(), predict_pair(pair));
		end
	end

endmodule

// ----- sim/segment_pair_distance_2d_tb.sv -----
// stimulus, flow control and verdict for the segment pair distance block
`timescale 1ns / 100ps

module segment_pair_distance_2d_tb;
	import spd2_pkg::*;

	localparam int CYCLE_LIMIT = 600000;

	logic  clk;
	logic  arst_n;
	logic  pair_valid;
	logic  pair_stall;
	pair_t pair;
	logic  dist_valid;
	logic  dist_stall;
	dist_t result;
	int    fails;
	int    pending;
	int    cycles = 0;
	int    idle_pct;
	int    stall_pct;
	logic  stall_seen;

	segment_pair_distance_2d dut (
		.clk(clk), .arst_n(arst_n),
		.pair_valid(pair_valid), .pair_stall(pair_stall), .pair(pair),
		.dist_valid(dist_valid), .dist_stall(dist_stall), .result(result)
	);

	segment_pair_distance_2d_chk chk (
		.clk(clk), .arst_n(arst_n),
		.pair_valid(pair_valid), .pair_stall(pair_stall), .pair(pair),
		.dist_valid(dist_valid), .dist_stall(dist_stall), .result(result),
		.fails(fails), .pending(pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// outputs settle after the rising edge, so the falling edge value holds at the next one
	always @(negedge clk)
		stall_seen <= pair_stall;

	// receiver back-pressure
	always @(posedge clk)
		dist_stall <= ($urandom_range(99) < stall_pct);

	// run-away guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// present one pair and hold it until the transfer
	task automatic send_pair(pair_t p);
		while ($urandom_range(99) < idle_pct) begin
			pair_valid <= 1'b0;
			@(posedge clk);
		end
		pair <= p;
		pair_valid <= 1'b1;
		do @(posedge clk); while (stall_seen);
	endtask

	task automatic send_segs(int ax, int ay, int bx, int by, int cx, int cy, int dx, int dy);
		pair_t p;
		p.seg1_start_x = coord_t'(ax); p.seg1_start_y = coord_t'(ay);
		p.seg1_end_x   = coord_t'(bx); p.seg1_end_y   = coord_t'(by);
		p.seg2_start_x = coord_t'(cx); p.seg2_start_y = coord_t'(cy);
		p.seg2_end_x   = coord_t'(dx); p.seg2_end_y   = coord_t'(dy);
		send_pair(p);
	endtask

	function automatic int near_coord(int base, int spread);
		int v;
		v = base + $urandom_range(2 * spread) - spread;
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return v;
	endfunction

	// random pair: mostly near-lying geometry, some full range and degenerate shapes
	task automatic send_random();
		int kind, bx, by, sp, ax, ay, cx, cy, dx, dy, k;
		pair_t p;
		kind = $urandom_range(9);
		sp = ($urandom_range(3) == 0) ? 30000 : (($urandom_range(1) == 0) ? 8 : 500);
		bx = $signed(16'($urandom));
		by = $signed(16'($urandom));
		ax = near_coord(bx, sp); ay = near_coord(by, sp);
		cx = near_coord(bx, sp); cy = near_coord(by, sp);
		dx = near_coord(bx, sp); dy = near_coord(by, sp);
		case (kind)
			0, 1: begin
				p = pair_t'({$urandom, $urandom, $urandom, $urandom});
				send_pair(p);
			end
			2: send_segs(ax, ay, ax, ay, cx, cy, dx, dy);
			3: send_segs(ax, ay, near_coord(ax, sp), near_coord(ay, sp), cx, cy, cx, cy);
			4: begin
				// collinear along a shared direction for even k, nearly so for odd k
				k = $urandom_range(4);
				send_segs(bx, by, near_coord(bx + 2 * k, 0), near_coord(by + k, 0),
					near_coord(bx + k, 0), near_coord(by + (k + 1) / 2, 0),
					near_coord(bx + 4 * k, 0), near_coord(by + 2 * k, 0));
			end
			5: send_segs(ax, ay, cx, cy, cx, cy, dx, dy);
			6: send_segs(ax, ay, dx, dy, near_coord(ax, 3), near_coord(ay, 3), cx, cy);
			default: send_segs(ax, ay, near_coord(bx, sp), near_coord(by, sp), cx, cy, dx, dy);
		endcase
	endtask

	task automatic drain();
		while (pending != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	initial begin
		idle_pct = 0;
		stall_pct = 0;
		arst_n = 1'b0;
		pair_valid = 1'b0;
		pair = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed cases
		send_segs(-10, 0, 10, 0, 0, -10, 0, 10);
		send_segs(0, 0, 10, 0, 10, 0, 20, 5);
		send_segs(0, 0, 10, 10, 10, 10, 0, 20);
		send_segs(0, 0, 10, 0, 0, 5, 10, 5);
		send_segs(0, 0, 10, 0, 5, 0, 20, 0);
		send_segs(0, 0, 10, 0, 12, 0, 20, 0);
		send_segs(3, 4, 3, 4, 0, 0, 0, 0);
		send_segs(3, 4, 3, 4, -5, 0, 5, 0);
		send_segs(-5, 7, 5, 7, 1, 1, 1, 1);
		send_segs(0, 0, 10, 0, 5, 3, 5, 1);
		send_segs(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
		send_segs(-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767);
		send_segs(-32768, -32768, -32768, 32767, 32767, -32768, 32767, 32767);
		send_segs(-32768, 32767, 32767, 32767, -32768, -32768, 32767, -32768);
		send_segs(-32768, -32768, 32767, -32767, 32767, 32767, -32768, 32766);
		send_segs(-1, -1, -1, -1, -1, -1, -1, -1);
		send_segs(0, 0, 1, 2, 5, 5, 9, 1);
		send_segs(0, 0, 7, 3, 1, 5, 9, 11);

		// hold off until the pipeline has emptied
		pair_valid <= 1'b0;
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 10 : 82) : 0;
			stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 10 : 82) : 0;
			repeat (200) send_random();
		end
		pair_valid <= 1'b0;
		stall_pct = 0;
		drain();

		if (fails == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
